@@ hdl/bwn_pkg.sv @@
// ----------------------------------------------------------------------------
// bwn_pkg
// Shared types, sizes and helpers for the boundary winding number block.
// ----------------------------------------------------------------------------
package bwn_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned TolW    = 8;
  localparam int unsigned HalfW   = 14;
  localparam int unsigned WindW   = 14;
  localparam int unsigned ProdW   = 2 * SampleW;
  localparam int unsigned DeltaW  = 3;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [HalfW-1:0]   half_t;
  typedef logic signed [DeltaW-1:0]  delta_t;
  typedef logic signed [ProdW-1:0]   prod_t;

  typedef struct packed {
    logic    en;
    logic    flip;
    logic    neg0;
    delta_t  axis_delta;
    sample_t cr;
    sample_t ci;
    sample_t nr;
    sample_t ni;
  } edge_t;

  typedef struct packed {
    edge_t ea;
    edge_t eb;
    logic  last;
  } entry_t;

  function automatic half_t sat_add(half_t h, delta_t d);
    logic signed [HalfW:0] s;
    s = {h[HalfW-1], h} + (HalfW+1)'(d);
    if (s > (HalfW+1)'($signed(2**(HalfW-1) - 1)))
      return half_t'(2**(HalfW-1) - 1);
    else if (s < -(HalfW+1)'($signed(2**(HalfW-1))))
      return {1'b1, {(HalfW-1){1'b0}}};
    else
      return s[HalfW-1:0];
  endfunction

endpackage

@@ hdl/bwn_front.sv @@
// ----------------------------------------------------------------------------
// bwn_front
// Accepts samples, tracks first and previous points, classifies both edges.
// ----------------------------------------------------------------------------
module bwn_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [bwn_pkg::TolW-1:0] tol,
  input  logic                     take,
  input  bwn_pkg::sample_t         sample_re,
  input  bwn_pkg::sample_t         sample_im,
  input  logic                     is_last,
  output bwn_pkg::entry_t          entry
);
  import bwn_pkg::*;

  sample_t first_re_r, first_im_r, first_re_nxt, first_im_nxt;
  sample_t prev_re_r, prev_im_r;
  logic    have_first_r, have_first_nxt;
  sample_t close_re, close_im;

  function automatic logic on_axis(sample_t v, logic [TolW-1:0] t);
    logic [SampleW:0] a;
    a = v[SampleW-1] ? -{v[SampleW-1], v} : {1'b0, v};
    return a < (SampleW+1)'(t);
  endfunction

  function automatic edge_t classify(sample_t cr, sample_t ci, sample_t nr,
                                     sample_t ni, logic en, logic [TolW-1:0] t);
    edge_t e;
    e.en   = en;
    e.neg0 = ci[SampleW-1];
    e.flip = ci[SampleW-1] ^ ni[SampleW-1];
    e.cr   = cr;
    e.ci   = ci;
    e.nr   = nr;
    e.ni   = ni;
    if (on_axis(ci, t) && cr[SampleW-1])
      e.axis_delta = ni[SampleW-1] ? delta_t'(1) : delta_t'(-1);
    else if (on_axis(ni, t) && nr[SampleW-1])
      e.axis_delta = ci[SampleW-1] ? delta_t'(-1) : delta_t'(1);
    else
      e.axis_delta = '0;
    return e;
  endfunction

  assign close_re = have_first_r ? first_re_r : sample_re;
  assign close_im = have_first_r ? first_im_r : sample_im;

  always_comb begin
    entry.ea   = classify(prev_re_r, prev_im_r, sample_re, sample_im, have_first_r, tol);
    entry.eb   = classify(sample_re, sample_im, close_re, close_im, is_last, tol);
    entry.last = is_last;
  end

  always_comb begin
    first_re_nxt   = close_re;
    first_im_nxt   = close_im;
    have_first_nxt = !is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_first_r <= 1'b0;
      first_re_r   <= '0;
      first_im_r   <= '0;
      prev_re_r    <= '0;
      prev_im_r    <= '0;
    end else if (take) begin
      have_first_r <= have_first_nxt;
      first_re_r   <= first_re_nxt;
      first_im_r   <= first_im_nxt;
      prev_re_r    <= sample_re;
      prev_im_r    <= sample_im;
    end
  end

endmodule

@@ hdl/bwn_queue.sv @@
// ----------------------------------------------------------------------------
// bwn_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module bwn_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bwn_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output bwn_pkg::entry_t pop_data
);
  import bwn_pkg::*;

  entry_t            mem_r [QDepth];
  logic [QPtrW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0]  count_r, count_nxt;

  assign full      = count_r == QCntW'(QDepth);
  assign not_empty = count_r != '0;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop)
      count_nxt = count_r + 1'b1;
    else if (pop && !push)
      count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push)
      mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)
        wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)
        rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

@@ hdl/bwn_back.sv @@
// ----------------------------------------------------------------------------
// bwn_back
// Forms crossing products, accumulates half counts, emits the rounded result.
// ----------------------------------------------------------------------------
module bwn_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_not_empty,
  input  bwn_pkg::entry_t           q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [bwn_pkg::WindW-1:0] out_winding
);
  import bwn_pkg::*;

  typedef struct packed {
    logic   en;
    logic   flip;
    logic   neg0;
    delta_t axis_delta;
    prod_t  a;
    prod_t  b;
  } prod_edge_t;

  prod_edge_t pa_r, pb_r;
  logic       s1_valid_r, s1_last_r;
  half_t      half_count_r, half_count_nxt;
  logic       out_valid_r;
  logic signed [WindW-1:0] winding_r, winding_nxt;
  logic       advance;
  delta_t     da, db;
  half_t      h1, h2;
  logic signed [HalfW:0] h15, mag;

  function automatic prod_edge_t mult(edge_t e);
    prod_edge_t p;
    p.en         = e.en;
    p.flip       = e.flip;
    p.neg0       = e.neg0;
    p.axis_delta = e.axis_delta;
    p.a          = e.ci * e.nr;
    p.b          = e.cr * e.ni;
    return p;
  endfunction

  function automatic delta_t edge_delta(prod_edge_t p);
    delta_t d;
    d = '0;
    if (p.en) begin
      if (p.flip) begin
        if (p.neg0 ? (p.a > p.b) : (p.a < p.b))
          d = p.neg0 ? delta_t'(-2) : delta_t'(2);
      end else begin
        d = p.axis_delta;
      end
    end
    return d;
  endfunction

  assign advance     = !out_valid_r || !out_stall;
  assign q_pop       = advance && q_not_empty;
  assign out_valid   = out_valid_r;
  assign out_winding = winding_r;

  always_comb begin
    da  = edge_delta(pa_r);
    db  = edge_delta(pb_r);
    h1  = sat_add(half_count_r, da);
    h2  = sat_add(h1, db);
    h15 = {h2[HalfW-1], h2};
    if (!h2[HalfW-1]) begin
      mag         = (h15 + 1'b1) >>> 1;
      winding_nxt = mag[WindW-1:0];
    end else begin
      mag         = (-h15 + 1'b1) >>> 1;
      winding_nxt = -mag[WindW-1:0];
    end
    half_count_nxt = s1_last_r ? '0 : h2;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pa_r      <= mult(q_data.ea);
      pb_r      <= mult(q_data.eb);
      s1_last_r <= q_data.last;
      if (s1_valid_r && s1_last_r)
        winding_r <= winding_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      half_count_r <= '0;
    end else if (advance) begin
      s1_valid_r  <= q_not_empty;
      out_valid_r <= s1_valid_r && s1_last_r;
      if (s1_valid_r)
        half_count_r <= half_count_nxt;
    end
  end

endmodule

@@ hdl/boundary_winding_number.sv @@
// ----------------------------------------------------------------------------
// boundary_winding_number
// Winding number of a closed sampled path about the origin.
// ----------------------------------------------------------------------------
// Samples enter one per cycle in path order while in_stall is low; the item
// marked last closes the path back to the first sample and yields one signed
// winding result via the queue entry, product and output registers when the
// output is free. Each cycle the back end evaluates the incoming and closing
// edges with two multiplier pairs, so one item per clock is sustained while
// out_stall is low; a four-entry queue lets input flow on during a stall.
// ----------------------------------------------------------------------------
module boundary_winding_number (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bwn_pkg::sample_t                  in_sample_re,
  input  bwn_pkg::sample_t                  in_sample_im,
  input  logic                              in_is_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [bwn_pkg::WindW-1:0]  out_winding,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bwn_pkg::TolW-1:0]          cfg_axis_tolerance
);
  import bwn_pkg::*;

  logic [TolW-1:0] tol_r;
  logic            take, q_full, q_pop, q_not_empty;
  entry_t          f_entry, q_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign take      = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n)
      tol_r <= TolW'(1);
    else if (cfg_valid && cfg_ready)
      tol_r <= cfg_axis_tolerance;
  end

  bwn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .tol       (tol_r),
    .take      (take),
    .sample_re (in_sample_re),
    .sample_im (in_sample_im),
    .is_last   (in_is_last),
    .entry     (f_entry)
  );

  bwn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_data (f_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  bwn_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_winding (out_winding)
  );

endmodule
